// ===== hw/rtl/pip_pkg.sv =====
// Package for the point-in-polygon filter: operation codes, the stored vertex
// format, controller state codes and the command and status bundles.
// No dependencies.
package pip_pkg;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} vertex_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic start;
		logic rd_en;
		logic out_load;
	} pip_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} pip_status_t;

endpackage

// ===== hw/rtl/pip_ctrl.sv =====
// Controller of the point-in-polygon filter: input handshake, vertex count
// register and the sequencer that walks the vertex table once per test.
// Depends on pip_pkg.
module pip_ctrl
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [4:0]                        cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  pip_status_t                       status,
	output pip_cmd_t                          cmd,
	output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	state_t          state_q;
	logic [4:0]      vertex_count_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   n_sat;
	logic            accept;

	assign n_sat = (32'(vertex_count_q) > 32'(MAX_VERTICES)) ?
		CW'(MAX_VERTICES) : CW'(vertex_count_q);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign rd_addr  = (k_q == n_q) ? '0 : AW'(k_q);

	always_comb begin
		cmd.wr_en    = accept && (operation == OP_LOAD);
		cmd.start    = accept && (operation == OP_TEST);
		cmd.rd_en    = (state_q == ST_ISSUE);
		cmd.out_load = (state_q == ST_DRAIN) && !status.busy && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						n_q     <= n_sat;
						k_q     <= '0;
						state_q <= (n_sat == '0) ? ST_DRAIN : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_q == n_q) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/pip_datapath.sv =====
// Datapath of the point-in-polygon filter: vertex memory, the edge pipeline
// with exact cross-multiplied abscissa test, crossing parity and output register.
// Depends on pip_pkg.
module pip_datapath
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pip_cmd_t                          cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
	output pip_status_t                       status,
	input  logic [3:0]                        vertex_index,
	input  logic signed [31:0]                coord_x,
	input  logic signed [31:0]                coord_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [31:0]                point_x,
	output logic signed [31:0]                point_y,
	output logic                              keep
);

	localparam int AW = $clog2(MAX_VERTICES);

	vertex_t            mem [MAX_VERTICES];
	vertex_t            rdata_q;
	vertex_t            prev_q;
	logic               rd_valid_q;
	logic               first_q;
	logic               idx_ok;
	logic [AW-1:0]      wr_addr;
	logic               edge_valid;

	logic signed [31:0] px_q;
	logic signed [31:0] py_q;

	logic               v_s1;
	logic signed [31:0] x1_s1;
	logic signed [31:0] y1_s1;
	logic signed [31:0] x2_s1;
	logic signed [31:0] y2_s1;
	logic               horiz_s1;

	logic               v_s2;
	logic               pre_s2;
	logic               vert_s2;
	logic               neg_a_s2;
	logic               neg_dx_s2;
	logic [31:0]        ma_s2;
	logic [31:0]        mdy_s2;
	logic [31:0]        mdx_s2;
	logic [31:0]        mb_s2;

	logic               v_s3;
	logic               pre_s3;
	logic               vert_s3;
	logic               neg_a_s3;
	logic               neg_dx_s3;
	logic [63:0]        left_s3;
	logic [63:0]        right_s3;

	logic               parity_q;
	logic               out_valid_q;
	logic signed [31:0] point_x_q;
	logic signed [31:0] point_y_q;
	logic               keep_q;

	logic               swap;
	logic [32:0]        pxe;
	logic [32:0]        pye;
	logic [32:0]        x1e;
	logic [32:0]        y1e;
	logic [32:0]        x2e;
	logic [32:0]        y2e;
	logic [32:0]        d_pos_a;
	logic [32:0]        d_neg_a;
	logic [32:0]        d_pos_dx;
	logic [32:0]        d_neg_dx;
	logic [32:0]        d_dy;
	logic [32:0]        d_b;
	logic               in_band;
	logic               left_ok;
	logic               ln;
	logic               rn;
	logic               prod_le;
	logic               crossing;

	assign idx_ok     = (32'(vertex_index) < 32'(MAX_VERTICES));
	assign wr_addr    = AW'(vertex_index);
	assign edge_valid = rd_valid_q && !first_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && idx_ok) begin
			mem[wr_addr] <= '{y: coord_y, x: coord_x};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Stage 1: order the edge so that its second end has the larger y.
	assign swap = (prev_q.y > rdata_q.y);

	// Stage 2: band and side checks, and the magnitudes of the differences.
	assign pxe      = {px_q[31], px_q};
	assign pye      = {py_q[31], py_q};
	assign x1e      = {x1_s1[31], x1_s1};
	assign y1e      = {y1_s1[31], y1_s1};
	assign x2e      = {x2_s1[31], x2_s1};
	assign y2e      = {y2_s1[31], y2_s1};
	assign d_pos_a  = pxe - x1e;
	assign d_neg_a  = x1e - pxe;
	assign d_pos_dx = x2e - x1e;
	assign d_neg_dx = x1e - x2e;
	assign d_dy     = y2e - y1e;
	assign d_b      = pye - y1e;
	assign in_band  = (py_q > y1_s1) && (py_q <= y2_s1);
	assign left_ok  = (px_q <= x1_s1) || (px_q <= x2_s1);

	// Stage 4: signed comparison of the two products.
	assign ln       = neg_a_s3 && (left_s3 != '0);
	assign rn       = neg_dx_s3 && (right_s3 != '0);
	assign prod_le  = (ln != rn) ? ln : (ln ? (left_s3 >= right_s3) : (left_s3 <= right_s3));
	assign crossing = pre_s3 && (vert_s3 || prod_le);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (rd_valid_q) begin
			prev_q <= rdata_q;
		end
		x1_s1     <= swap ? rdata_q.x : prev_q.x;
		y1_s1     <= swap ? rdata_q.y : prev_q.y;
		x2_s1     <= swap ? prev_q.x : rdata_q.x;
		y2_s1     <= swap ? prev_q.y : rdata_q.y;
		horiz_s1  <= (prev_q.y == rdata_q.y);
		pre_s2    <= !horiz_s1 && in_band && left_ok;
		vert_s2   <= (x1_s1 == x2_s1);
		neg_a_s2  <= (px_q < x1_s1);
		neg_dx_s2 <= (x2_s1 < x1_s1);
		ma_s2     <= (px_q < x1_s1) ? d_neg_a[31:0] : d_pos_a[31:0];
		mdx_s2    <= (x2_s1 < x1_s1) ? d_neg_dx[31:0] : d_pos_dx[31:0];
		mdy_s2    <= d_dy[31:0];
		mb_s2     <= d_b[31:0];
		pre_s3    <= pre_s2;
		vert_s3   <= vert_s2;
		neg_a_s3  <= neg_a_s2;
		neg_dx_s3 <= neg_dx_s2;
		left_s3   <= 64'(ma_s2) * 64'(mdy_s2);
		right_s3  <= 64'(mdx_s2) * 64'(mb_s2);
		if (cmd.out_load) begin
			point_x_q <= px_q;
			point_y_q <= py_q;
			keep_q    <= parity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q  <= 1'b0;
			first_q     <= 1'b1;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= cmd.rd_en;
			if (cmd.start) begin
				first_q <= 1'b1;
			end else if (rd_valid_q) begin
				first_q <= 1'b0;
			end
			v_s1 <= edge_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.start) begin
				parity_q <= 1'b0;
			end else if (v_s3) begin
				parity_q <= parity_q ^ crossing;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.busy     = rd_valid_q || v_s1 || v_s2 || v_s3;
		status.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;
	assign keep      = keep_q;

endmodule

// ===== hw/rtl/point_in_polygon_filter_core.sv =====
// Top level of the point-in-polygon filter: joins the controller and the datapath.
// Depends on pip_pkg, pip_ctrl and pip_datapath.
//
// Usage: the input channel (in_valid, in_stall) carries one transaction per item.
// operation selects a vertex load, which writes vertex_index of the table from
// coord_x and coord_y and gives no result, or a point test. Loads with an index
// at or above MAX_VERTICES are dropped. The vertex count is written through
// cfg_wr_en and cfg_wr_data while the block is idle; counts above MAX_VERTICES
// are taken as MAX_VERTICES. Every table entry below the count must be loaded
// before a test.
// A test of a polygon of n vertices reads the table once, one vertex per cycle
// from a single memory read port, and pushes one edge per cycle through a
// four-stage edge pipeline. For n >= 1 the result transaction (point_x, point_y, keep)
// appears once the last edge has left the pipeline and the output register is free,
// in the same cycle in which the next item can be taken; an empty polygon reads no
// vertex. A load does not stall the input.
// The result waits in an output register while out_stall is high; loads and a
// new test are still accepted, and a finished test waits until that register
// is free. Reset clears the controller, the pipeline, the output valid and the
// vertex count; the vertex table itself is not cleared.
module point_in_polygon_filter_core
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [3:0]         vertex_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic               keep
);

	localparam int AW = $clog2(MAX_VERTICES);

	pip_cmd_t    cmd;
	pip_status_t status;
	logic [AW-1:0] rd_addr;

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.status      (status),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.status       (status),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.keep         (keep)
	);

endmodule

// ===== hw/rtl/pip_checker.sv =====
// Port-level checker for the point-in-polygon filter and its bind to the top level.
// Depends on pip_pkg and point_in_polygon_filter_core.
module pip_checker
	import pip_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               operation,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic               keep
);

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(keep))
		else $error("result changed while stalled");

	// A result leaves only through a completed transaction.
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without a transaction");

	// A test occupies the block for the following cycle.
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == OP_TEST) |=> in_stall)
		else $error("input taken again straight after a test");

	// A vertex load leaves the input ready on the following cycle.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == OP_LOAD) |=> !in_stall)
		else $error("input stalled after a vertex load");

endmodule

bind point_in_polygon_filter_core pip_checker u_pip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operation (operation),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.point_x   (point_x),
	.point_y   (point_y),
	.keep      (keep)
);
